/* hw/rtl/tce_pkg.sv */
`timescale 1ns / 1ps
package tce_pkg;

    // Default sizes
    localparam int CELL_BITS_DEF      = 16;
    localparam int REG_INDEX_BITS_DEF = 3;
    localparam int ADDR_BITS_DEF      = 12;

    // Field widths on the streams
    localparam int CMD_W     = 6;
    localparam int OPND_W    = 16;
    localparam int FLAG_W    = 5;
    localparam int WVAL_W    = 16;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    // Flag bit positions
    localparam int F_CF = 0;
    localparam int F_PF = 1;
    localparam int F_ZF = 2;
    localparam int F_OF = 3;
    localparam int F_SF = 4;

    // Instruction codes
    localparam logic [CMD_W-1:0] CMD_NOP      = 6'd0;
    localparam logic [CMD_W-1:0] CMD_MOV_BASE = 6'd1;
    localparam logic [CMD_W-1:0] CMD_MOV_LAST = 6'd6;
    localparam logic [CMD_W-1:0] CMD_LD_REG   = 6'd7;
    localparam logic [CMD_W-1:0] CMD_LD_MEM   = 6'd8;
    localparam logic [CMD_W-1:0] CMD_ST_REG   = 6'd9;
    localparam logic [CMD_W-1:0] CMD_ST_MEM   = 6'd10;
    localparam logic [CMD_W-1:0] CMD_ADD_BASE = 6'd11;
    localparam logic [CMD_W-1:0] CMD_ADD_LAST = 6'd16;
    localparam logic [CMD_W-1:0] CMD_SUB_BASE = 6'd17;
    localparam logic [CMD_W-1:0] CMD_SUB_LAST = 6'd22;
    localparam logic [CMD_W-1:0] CMD_MUL_REG  = 6'd23;
    localparam logic [CMD_W-1:0] CMD_MUL_MEM  = 6'd24;
    localparam logic [CMD_W-1:0] CMD_CMP_BASE = 6'd25;
    localparam logic [CMD_W-1:0] CMD_CMP_LAST = 6'd30;
    localparam logic [CMD_W-1:0] CMD_AND      = 6'd31;
    localparam logic [CMD_W-1:0] CMD_OR       = 6'd32;
    localparam logic [CMD_W-1:0] CMD_XOR      = 6'd33;
    localparam logic [CMD_W-1:0] CMD_SHL      = 6'd34;
    localparam logic [CMD_W-1:0] CMD_SHR      = 6'd35;
    localparam logic [CMD_W-1:0] CMD_JMP      = 6'd36;
    localparam logic [CMD_W-1:0] CMD_JA       = 6'd37;
    localparam logic [CMD_W-1:0] CMD_JC       = 6'd38;
    localparam logic [CMD_W-1:0] CMD_JE       = 6'd39;
    localparam logic [CMD_W-1:0] CMD_JG       = 6'd40;
    localparam logic [CMD_W-1:0] CMD_JL       = 6'd41;
    localparam logic [CMD_W-1:0] CMD_JO       = 6'd42;
    localparam logic [CMD_W-1:0] CMD_JP       = 6'd43;
    localparam logic [CMD_W-1:0] CMD_JS       = 6'd44;
    localparam logic [CMD_W-1:0] CMD_JZ       = 6'd45;

    // Operand modes within MOV/ADD/SUB/CMP
    localparam logic [2:0] MODE_RR = 3'd0;
    localparam logic [2:0] MODE_RM = 3'd1;
    localparam logic [2:0] MODE_MR = 3'd2;
    localparam logic [2:0] MODE_MM = 3'd3;
    localparam logic [2:0] MODE_IR = 3'd4;
    localparam logic [2:0] MODE_IM = 3'd5;

endpackage

/* hw/rtl/tce_ram.sv */
`timescale 1ns / 1ps
module tce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* hw/rtl/toy_cpu_execute_unit_core.sv */
`timescale 1ns / 1ps
// Execute unit of a small CPU: one decoded instruction per request on the s_ stream,
// one result (jump taken, flags, written value) per instruction on the m_ stream. The
// register file is in flip-flops; data memory is a single-port RAM with a registered
// read, addressed relative to the instruction pointer. Each instruction goes through the
// steps accept and first memory read, second read, then execute and write-back, as the
// two dependent reads share the single memory port. After reset the memory is cleared,
// one entry a cycle, all 2^ADDR_BITS entries (4096 by default), before the first request
// is accepted. A finished result waits in the output register while the next request
// is read; execution stalls only if that result is still untaken.
module toy_cpu_execute_unit_core
    import tce_pkg::*;
#(
    parameter int CELL_BITS      = CELL_BITS_DEF,
    parameter int REG_INDEX_BITS = REG_INDEX_BITS_DEF,
    parameter int ADDR_BITS      = ADDR_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [5:0] cmd, [21:6] src_operand, [37:22] dst_operand, [39:38] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] jump_taken, [5:1] flag_bits, [21:6] written_value, [23:22] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int OP_W      = (CELL_BITS < OPND_W) ? CELL_BITS : OPND_W;
    localparam int REG_COUNT = 1 << REG_INDEX_BITS;
    localparam int RI        = REG_INDEX_BITS;
    localparam logic [RI-1:0] R_ACC   = '0;
    localparam logic [RI-1:0] R_IP    = RI'(REG_COUNT - 2);
    localparam logic [RI-1:0] R_FLAGS = RI'(REG_COUNT - 1);

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RD1, ST_EXEC} state_t;

    state_t               state_reg;
    logic [ADDR_BITS-1:0] clr_cnt_reg;
    logic [CMD_W-1:0]     cmd_reg;
    logic [CELL_BITS-1:0] src_reg, dst_reg, a_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [CELL_BITS-1:0] rf_reg [REG_COUNT];
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic [CELL_BITS-1:0] s_src_c, s_dst_c;
    logic [RI-1:0]        rd_idx;
    logic [CELL_BITS-1:0] rf_rd, ip, acc, flags_old;
    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_addr;
    logic [CELL_BITS-1:0] ram_wdata, ram_rdata;

    // Decode
    logic                 is_mov, is_add, is_sub, is_cmp, is_grp, is_ld, is_st, is_mul;
    logic                 is_logic, is_jmp;
    logic [2:0]           mode;
    logic                 a_from_mem, a_from_imm;
    logic [CELL_BITS-1:0] a_val, off;

    // Execute
    logic                 fire;
    logic [CELL_BITS-1:0] b, res, new_ip, flags_set;
    logic                 wr, wr_mem, set_fl, cf, cond;
    logic [RI-1:0]        wr_idx;
    logic [FLAG_W-1:0]    f_new, f_out;
    logic [CELL_BITS:0]   ip_sum_in, ip_sum_off;

    assign s_src_c = CELL_BITS'(s_tdata[CMD_W +: OP_W]);
    assign s_dst_c = CELL_BITS'(s_tdata[CMD_W+OPND_W +: OP_W]);

    assign rd_idx    = (state_reg == ST_RD1) ? src_reg[RI-1:0] : dst_reg[RI-1:0];
    assign rf_rd     = rf_reg[rd_idx];
    assign ip        = rf_reg[R_IP];
    assign acc       = rf_reg[R_ACC];
    assign flags_old = rf_reg[R_FLAGS];

    // Decode the held instruction
    always_comb begin
        is_mov   = cmd_reg inside {[CMD_MOV_BASE:CMD_MOV_LAST]};
        is_add   = cmd_reg inside {[CMD_ADD_BASE:CMD_ADD_LAST]};
        is_sub   = cmd_reg inside {[CMD_SUB_BASE:CMD_SUB_LAST]};
        is_cmp   = cmd_reg inside {[CMD_CMP_BASE:CMD_CMP_LAST]};
        is_grp   = is_mov | is_add | is_sub | is_cmp;
        is_ld    = cmd_reg inside {CMD_LD_REG, CMD_LD_MEM};
        is_st    = cmd_reg inside {CMD_ST_REG, CMD_ST_MEM};
        is_mul   = cmd_reg inside {CMD_MUL_REG, CMD_MUL_MEM};
        is_logic = cmd_reg inside {[CMD_AND:CMD_SHR]};
        is_jmp   = cmd_reg inside {[CMD_JMP:CMD_JZ]};
        if (is_mov)      mode = 3'(cmd_reg - CMD_MOV_BASE);
        else if (is_add) mode = 3'(cmd_reg - CMD_ADD_BASE);
        else if (is_sub) mode = 3'(cmd_reg - CMD_SUB_BASE);
        else             mode = 3'(cmd_reg - CMD_CMP_BASE);
        a_from_imm = is_grp && (mode == MODE_IR || mode == MODE_IM);
        a_from_mem = (is_grp && (mode == MODE_MR || mode == MODE_MM))
                     || cmd_reg == CMD_LD_MEM || cmd_reg == CMD_ST_MEM
                     || cmd_reg == CMD_MUL_MEM;
        a_val = a_from_imm ? src_reg : (a_from_mem ? ram_rdata : rf_rd);
        off   = (is_ld || is_st) ? a_val : dst_reg;
    end

    // Memory address: clear sweep, first read, second read, then hold for write-back
    assign ip_sum_in  = {1'b0, ip} + {1'b0, s_src_c};
    assign ip_sum_off = {1'b0, ip} + {1'b0, off};
    always_comb begin
        case (state_reg)
            ST_CLEAR: ram_addr = clr_cnt_reg;
            ST_IDLE:  ram_addr = ADDR_BITS'(ip_sum_in);
            ST_RD1:   ram_addr = ADDR_BITS'(ip_sum_off);
            default:  ram_addr = addr_reg;
        endcase
    end

    assign fire      = (state_reg == ST_EXEC) && (!m_valid_reg || m_tready);
    assign ram_we    = (state_reg == ST_CLEAR) || (fire && wr && wr_mem);
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : res;

    // Execute the held instruction
    always_comb begin
        b      = is_mul ? acc : ((is_grp && mode[0]) ? ram_rdata : rf_rd);
        res    = '0;
        wr     = 1'b0;
        wr_mem = 1'b0;
        wr_idx = dst_reg[RI-1:0];
        set_fl = 1'b0;
        cf     = 1'b0;
        cond   = 1'b0;
        new_ip = ip + a_reg;
        if (is_grp) begin
            wr_mem = mode[0];
            if (is_mov) begin
                res = a_reg;
                wr  = 1'b1;
            end else if (is_add) begin
                res    = a_reg + b;
                cf     = res < b;
                set_fl = 1'b1;
                wr     = 1'b1;
            end else begin
                res    = b - a_reg;
                cf     = res > b;
                set_fl = 1'b1;
                wr     = is_sub;
            end
        end else if (is_ld) begin
            res    = ram_rdata;
            wr     = 1'b1;
            wr_idx = R_ACC;
        end else if (is_st) begin
            res    = acc;
            wr     = 1'b1;
            wr_mem = 1'b1;
        end else if (is_mul) begin
            res    = a_reg * acc;
            cf     = res < acc;
            set_fl = 1'b1;
            wr     = 1'b1;
            wr_idx = R_ACC;
        end else if (is_logic) begin
            wr = 1'b1;
            case (cmd_reg)
                CMD_AND: begin res = a_reg & b; set_fl = 1'b1; end
                CMD_OR:  begin res = a_reg | b; set_fl = 1'b1; end
                CMD_XOR: begin res = a_reg ^ b; set_fl = 1'b1; end
                CMD_SHL: res = (a_reg >= CELL_BITS'(CELL_BITS)) ? '0 : (b << a_reg);
                default: res = (a_reg >= CELL_BITS'(CELL_BITS)) ? '0 : (b >> a_reg);
            endcase
        end else if (is_jmp) begin
            case (cmd_reg)
                CMD_JMP: cond = 1'b1;
                CMD_JA:  cond = !flags_old[F_CF] && !flags_old[F_ZF];
                CMD_JC:  cond = flags_old[F_CF];
                CMD_JE:  cond = flags_old[F_ZF];
                CMD_JG:  cond = !flags_old[F_ZF] && (flags_old[F_SF] == flags_old[F_OF]);
                CMD_JL:  cond = flags_old[F_SF] != flags_old[F_OF];
                CMD_JO:  cond = flags_old[F_OF];
                CMD_JP:  cond = flags_old[F_PF];
                CMD_JS:  cond = flags_old[F_SF];
                default: cond = flags_old[F_ZF];
            endcase
        end
        f_new        = '0;
        f_new[F_CF]  = cf;
        f_new[F_PF]  = !res[0];
        f_new[F_ZF]  = (res == '0);
        f_new[F_OF]  = cf;
        f_new[F_SF]  = res[CELL_BITS-1];
        flags_set    = {flags_old[CELL_BITS-1:FLAG_W], f_new};
        if (wr && !wr_mem && wr_idx == R_FLAGS) f_out = res[FLAG_W-1:0];
        else if (set_fl)                        f_out = f_new;
        else                                    f_out = flags_old[FLAG_W-1:0];
    end

    // Sequencer, register file and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                rf_reg[i] <= '0;
            end
        end else begin
            if (m_valid_reg && m_tready && !fire) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (&clr_cnt_reg) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg   <= s_tdata[CMD_W-1:0];
                        src_reg   <= s_src_c;
                        dst_reg   <= s_dst_c;
                        state_reg <= ST_RD1;
                    end
                end
                ST_RD1: begin
                    a_reg     <= a_val;
                    addr_reg  <= ram_addr;
                    state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    if (fire) begin
                        // A register write to the flags register overrides the new flags
                        if (set_fl && !(wr && !wr_mem && wr_idx == R_FLAGS)) begin
                            rf_reg[R_FLAGS] <= flags_set;
                        end
                        if (is_jmp && cond)        rf_reg[R_IP]    <= new_ip;
                        if (wr && !wr_mem)         rf_reg[wr_idx]  <= res;
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {2'b00, wr ? WVAL_W'(res) : WVAL_W'(0), f_out,
                                        is_jmp && cond};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    tce_ram #(
        .WIDTH(CELL_BITS),
        .DEPTH(1 << ADDR_BITS)
    ) u_dmem (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

`ifndef SYNTH
    // An accepted request always moves on to the second read
    a_accept_rd1: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_RD1)
        else $error("request not followed by second read");

    // Memory writes only during the clear sweep or at execute
    a_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> state_reg == ST_CLEAR || state_reg == ST_EXEC)
        else $error("memory write outside clear or execute");

    // A new result appears only right after execute
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !$past(m_valid_reg) |-> $past(state_reg) == ST_EXEC)
        else $error("result without execute");

    // No request is taken during the clear sweep
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_tready)
        else $error("request accepted during clear");
`endif

endmodule
